// File: src/rdd_pkg.sv
// Shared types, constants and register codes for the recovery deploy decider.
// No dependencies; design files refer to it by scoped names, the testbench imports it.
package rdd_pkg;

    // Moving-average depth, kept as a power of two so the mean is a shift.
    localparam int AVG_LOG2  = 3;
    localparam int AVG_DEPTH = 1 << AVG_LOG2;

    localparam int TILT_W = 16;
    localparam int ALT_W  = 24;
    localparam int TIME_W = 31;
    localparam int SUM_W  = ALT_W + AVG_LOG2;

    localparam int TILT_THR_W = 15;
    localparam int DROP_THR_W = 17;
    localparam int TIME_THR_W = 31;
    localparam int WIN_W      = 10;
    localparam int CFG_DATA_W = 31;
    localparam int CFG_IDX_W  = 3;

    // time_ms mod 1000: divide (t >> 3) by 125 with a reciprocal.
    localparam int MS_PER_SEC = 1000;
    localparam int PRE_SHIFT  = 3;
    localparam int DIV_W      = TIME_W - PRE_SHIFT;
    localparam int RECIP_SH   = 35;
    localparam int RECIP_W    = 29;
    localparam longint RECIP_L = (64'd1 << RECIP_SH) / (MS_PER_SEC >> PRE_SHIFT);
    localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'(RECIP_L);
    localparam int PROD_W     = DIV_W + RECIP_W;
    localparam int Q_W        = PROD_W - RECIP_SH;
    localparam int REM_W      = 11;
    localparam logic [REM_W-1:0] MS_PER_SEC_R = REM_W'(MS_PER_SEC);

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAFETY_PIN     = 3'd0,
        CFG_LAUNCH_PIN     = 3'd1,
        CFG_TILT_THRESHOLD = 3'd2,
        CFG_DROP_THRESHOLD = 3'd3,
        CFG_TIME_THRESHOLD = 3'd4,
        CFG_TILT_WINDOW    = 3'd5
    } t_cfg_reg;

    typedef enum logic [2:0] {
        DEP_NONE   = 3'd0,
        DEP_TILT   = 3'd1,
        DEP_ALT    = 3'd2,
        DEP_TIME   = 3'd3,
        DEP_MANUAL = 3'd4
    } t_deploy;

    localparam logic [TILT_THR_W-1:0] RST_TILT_THR = TILT_THR_W'(7000);
    localparam logic [DROP_THR_W-1:0] RST_DROP_THR = DROP_THR_W'(300);
    localparam logic [TIME_THR_W-1:0] RST_TIME_THR = TIME_THR_W'(9000);
    localparam logic [WIN_W-1:0]      RST_TILT_WIN = WIN_W'(200);

    // Pre-judged sample handed from the window pipe to the decision stage.
    typedef struct packed {
        logic                    manual;
        logic                    tilt_fire;
        logic                    time_fire;
        logic signed [ALT_W-1:0] altitude;
    } t_judge;

endpackage

// File: src/recovery_deploy_decider_top.sv
// Top level of the recovery deploy decider: config registers, averaging chain,
// decision state. Depends on rdd_pkg, rdd_cell and rdd_window.
//
//  channel  | dir | handshake                     | payload
//  ---------+-----+-------------------------------+-------------------------------
//  s_axis   | in  | s_axis_tvalid / s_axis_tready | tilt, altitude, time, manual
//  m_axis   | out | m_axis_tvalid / m_axis_tready | type, deployed, servo, average
//  cfg      | in  | i_cfg_we (no wait)            | i_cfg_index, i_cfg_data
//
// One sample per cycle sustained while m_axis_tready holds high; an input transfer
// passes the two-stage time-mod-1000 pipe and then the decision stage.
// The decision stage closes a loop from the running sum and peak registers back to themselves.
// Synchronous active-low reset clears all state but the front-end data registers.
// Each stage moves when the one after it is empty or moving, so a stalled result
// does not block inputs until all three stages are full.
module recovery_deploy_decider_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [15:0] tilt_angle, [39:16] altitude, [70:40] time_ms, [71] manual_command
    input  logic [rdd_pkg::IN_DATA_W-1:0]        s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [2:0] deploy_type, [3] deployed, [4] servo_open, [28:5] average_altitude,
    // [31:29] zero
    output logic [rdd_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    input  logic                                 i_cfg_we,
    input  logic [rdd_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [rdd_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    // configuration
    logic                                 r_safety_pin;
    logic                                 r_launch_pin;
    logic [rdd_pkg::TILT_THR_W-1:0]       r_tilt_thr;
    logic [rdd_pkg::DROP_THR_W-1:0]       r_drop_thr;
    logic [rdd_pkg::TIME_THR_W-1:0]       r_time_thr;
    logic [rdd_pkg::WIN_W-1:0]            r_tilt_win;

    // decision state; these registers are also the output register
    logic                                 r_out_valid;
    logic signed [rdd_pkg::SUM_W-1:0]     r_sum;
    logic signed [rdd_pkg::ALT_W-1:0]     r_avg;
    logic signed [rdd_pkg::ALT_W-1:0]     r_peak;
    logic                                 r_flag;
    rdd_pkg::t_deploy                     r_type;
    logic                                 r_latch;

    logic signed [rdd_pkg::SUM_W-1:0]     n_sum;
    logic signed [rdd_pkg::ALT_W-1:0]     n_avg;
    logic signed [rdd_pkg::ALT_W-1:0]     n_peak;
    rdd_pkg::t_deploy                     n_type;

    logic                                 judge_valid;
    rdd_pkg::t_judge                      judge;
    logic                                 ready_out;
    logic                                 take;
    logic                                 armed;
    logic                                 push;
    logic signed [rdd_pkg::ALT_W:0]       drop;
    logic                                 drop_fire;

    logic signed [rdd_pkg::ALT_W-1:0]     tap_q [rdd_pkg::AVG_DEPTH];

    rdd_window u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_tilt     (s_axis_tdata[15:0]),
        .i_alt      (s_axis_tdata[39:16]),
        .i_time     (s_axis_tdata[70:40]),
        .i_manual   (s_axis_tdata[71]),
        .i_tilt_thr (r_tilt_thr),
        .i_time_thr (r_time_thr),
        .i_tilt_win (r_tilt_win),
        .o_valid    (judge_valid),
        .i_ready    (ready_out),
        .o_judge    (judge)
    );

    // config writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_safety_pin <= 1'b1;
            r_launch_pin <= 1'b1;
            r_tilt_thr   <= rdd_pkg::RST_TILT_THR;
            r_drop_thr   <= rdd_pkg::RST_DROP_THR;
            r_time_thr   <= rdd_pkg::RST_TIME_THR;
            r_tilt_win   <= rdd_pkg::RST_TILT_WIN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rdd_pkg::CFG_SAFETY_PIN:     r_safety_pin <= i_cfg_data[0];
                rdd_pkg::CFG_LAUNCH_PIN:     r_launch_pin <= i_cfg_data[0];
                rdd_pkg::CFG_TILT_THRESHOLD: r_tilt_thr   <= i_cfg_data[rdd_pkg::TILT_THR_W-1:0];
                rdd_pkg::CFG_DROP_THRESHOLD: r_drop_thr   <= i_cfg_data[rdd_pkg::DROP_THR_W-1:0];
                rdd_pkg::CFG_TIME_THRESHOLD: r_time_thr   <= i_cfg_data[rdd_pkg::TIME_THR_W-1:0];
                rdd_pkg::CFG_TILT_WINDOW:    r_tilt_win   <= i_cfg_data[rdd_pkg::WIN_W-1:0];
                default: ;
            endcase
        end
    end

    assign ready_out = !r_out_valid || m_axis_tready;
    assign take      = judge_valid && ready_out;
    assign armed     = !r_safety_pin && !r_launch_pin;
    // altitude path is reached only when neither manual nor tilt fired
    assign push      = take && armed && !judge.manual && !judge.tilt_fire;

    // Averaging chain: newest sample enters tap 0, the last tap is the oldest
    // and leaves the running sum on the same push.
    genvar g;
    generate
        for (g = 0; g < rdd_pkg::AVG_DEPTH; g++) begin : g_tap
            if (g == 0) begin : g_head
                rdd_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_shift (push),
                    .i_d     (judge.altitude),
                    .o_q     (tap_q[g])
                );
            end else begin : g_body
                rdd_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_shift (push),
                    .i_d     (tap_q[g-1]),
                    .o_q     (tap_q[g])
                );
            end
        end
    endgenerate

    always_comb begin
        n_sum  = r_sum - rdd_pkg::SUM_W'(tap_q[rdd_pkg::AVG_DEPTH-1])
                       + rdd_pkg::SUM_W'(judge.altitude);
        n_avg  = rdd_pkg::ALT_W'(n_sum >>> rdd_pkg::AVG_LOG2);
        n_peak = (n_avg >= r_peak) ? n_avg : r_peak;
        // negative when the new average tops the peak: never a drop
        drop      = {r_peak[rdd_pkg::ALT_W-1], r_peak} - {n_avg[rdd_pkg::ALT_W-1], n_avg};
        drop_fire = drop > $signed({{(rdd_pkg::ALT_W + 1 - rdd_pkg::DROP_THR_W){1'b0}},
                                    r_drop_thr});
    end

    always_comb begin
        if (judge.manual) begin
            n_type = rdd_pkg::DEP_MANUAL;
        end else if (judge.tilt_fire) begin
            n_type = rdd_pkg::DEP_TILT;
        end else if (drop_fire) begin
            n_type = rdd_pkg::DEP_ALT;
        end else if (judge.time_fire) begin
            n_type = rdd_pkg::DEP_TIME;
        end else begin
            n_type = rdd_pkg::DEP_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sum       <= '0;
            r_avg       <= '0;
            r_peak      <= '0;
            r_flag      <= 1'b0;
            r_type      <= rdd_pkg::DEP_NONE;
            r_latch     <= 1'b0;
        end else begin
            if (ready_out) begin
                r_out_valid <= judge_valid;
            end
            if (push) begin
                r_sum  <= n_sum;
                r_avg  <= n_avg;
                r_peak <= n_peak;
            end
            // gated samples leave the decision as it was
            if (take && armed) begin
                r_type <= n_type;
                r_flag <= n_type != rdd_pkg::DEP_NONE;
                if (n_type != rdd_pkg::DEP_NONE) begin
                    r_latch <= 1'b1;
                end
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_avg, r_latch, r_flag, r_type};

endmodule

// File: src/rdd_cell.sv
// One tap of the altitude averaging chain: holds a sample, passes it on.
// Depends on rdd_pkg for the altitude width.
module rdd_cell (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_shift,
    input  logic signed [rdd_pkg::ALT_W-1:0] i_d,
    output logic signed [rdd_pkg::ALT_W-1:0] o_q
);

    logic signed [rdd_pkg::ALT_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

// File: src/rdd_window.sv
// Two-stage front end: tilt window test (time mod 1000), tilt and time compares.
// Depends on rdd_pkg; produces a t_judge per sample with a valid/ready handshake.
module rdd_window (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [rdd_pkg::TILT_W-1:0]     i_tilt,
    input  logic signed [rdd_pkg::ALT_W-1:0]      i_alt,
    input  logic        [rdd_pkg::TIME_W-1:0]     i_time,
    input  logic                                  i_manual,
    input  logic        [rdd_pkg::TILT_THR_W-1:0] i_tilt_thr,
    input  logic        [rdd_pkg::TIME_THR_W-1:0] i_time_thr,
    input  logic        [rdd_pkg::WIN_W-1:0]      i_tilt_win,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output rdd_pkg::t_judge                       o_judge
);

    logic                                r_s1_valid;
    logic [rdd_pkg::PROD_W-1:0]          r_s1_prod;
    logic [rdd_pkg::TIME_W-1:0]          r_s1_time;
    logic                                r_s1_tilt_over;
    logic                                r_s1_time_hit;
    logic                                r_s1_manual;
    logic signed [rdd_pkg::ALT_W-1:0]    r_s1_alt;
    logic                                r_s2_valid;
    rdd_pkg::t_judge                     r_s2_judge;

    logic                                adv1;
    logic                                adv2;
    logic [rdd_pkg::PROD_W-1:0]          prod;
    logic                                tilt_over;
    logic [rdd_pkg::Q_W-1:0]             quot;
    logic [rdd_pkg::TIME_W-1:0]          back;
    logic [rdd_pkg::TIME_W-1:0]          diff;
    logic [rdd_pkg::REM_W-1:0]           rem_raw;
    logic [rdd_pkg::REM_W-1:0]           rem;
    logic                                in_window;
    rdd_pkg::t_judge                     n_judge;

    function automatic logic [rdd_pkg::Q_W-1:0] prod_hi(input logic [rdd_pkg::PROD_W-1:0] p);
        prod_hi = p[rdd_pkg::PROD_W-1:rdd_pkg::RECIP_SH];
    endfunction

    assign adv2    = !r_s2_valid || i_ready;
    assign adv1    = !r_s1_valid || adv2;
    assign o_ready = adv1;

    // Stage 1: reciprocal product of (t >> 3), threshold compares.
    assign prod = rdd_pkg::PROD_W'(i_time[rdd_pkg::TIME_W-1:rdd_pkg::PRE_SHIFT])
                * rdd_pkg::PROD_W'(rdd_pkg::RECIP_M);
    assign tilt_over = i_tilt > $signed({1'b0, i_tilt_thr});

    // Stage 2: remainder, one correction step (estimate is low by at most one).
    assign quot    = prod_hi(r_s1_prod);
    assign back    = rdd_pkg::TIME_W'(quot) * rdd_pkg::TIME_W'(rdd_pkg::MS_PER_SEC);
    assign diff    = r_s1_time - back;
    assign rem_raw = diff[rdd_pkg::REM_W-1:0];
    assign rem     = (rem_raw >= rdd_pkg::MS_PER_SEC_R) ? rem_raw - rdd_pkg::MS_PER_SEC_R
                                                        : rem_raw;
    assign in_window = rem < {1'b0, i_tilt_win};

    always_comb begin
        n_judge.manual    = r_s1_manual;
        n_judge.tilt_fire = r_s1_tilt_over && in_window;
        n_judge.time_fire = r_s1_time_hit;
        n_judge.altitude  = r_s1_alt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (adv1) begin
                r_s1_valid <= i_valid;
            end
            if (adv2) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_s1_prod      <= prod;
            r_s1_time      <= i_time;
            r_s1_tilt_over <= tilt_over;
            r_s1_time_hit  <= i_time >= i_time_thr;
            r_s1_manual    <= i_manual;
            r_s1_alt       <= i_alt;
        end
        if (adv2) begin
            r_s2_judge <= n_judge;
        end
    end

    assign o_valid = r_s2_valid;
    assign o_judge = r_s2_judge;

endmodule

// File: test/recovery_deploy_decider_top_tb.sv
// Self-checking testbench for recovery_deploy_decider_top: a directed plan, then
// randomized flight profiles under several flow-control phases. Needs rdd_pkg and the DUT.
module recovery_deploy_decider_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rdd_pkg::*;

    localparam int          CLK_HALF     = 6;
    localparam int unsigned CYCLE_LIMIT  = 300000;
    localparam int          PHASES       = 8;
    localparam int          PHASE_ITEMS  = 150;
    localparam int          HOLD_CYCLES  = 60;
    localparam int          SETTLE_WAIT  = 6;   // drain margin after the last decision

    // one sensor sample as it travels on s_axis
    typedef struct {
        logic signed [TILT_W-1:0] tilt;
        logic signed [ALT_W-1:0]  alt;
        logic [TIME_W-1:0]        time_ms;
        logic                     manual;
    } sample_t;

    // one decision as it travels on m_axis
    typedef struct {
        t_deploy                  kind;
        logic                     deployed;
        logic                     servo;
        logic signed [ALT_W-1:0]  avg;
    } outcome_t;

    // directed plan row: either a register write or a sample
    typedef struct {
        bit                       is_cfg;
        t_cfg_reg                 reg_id;
        logic [CFG_DATA_W-1:0]    value;
        sample_t                  smp;
        bit                       typed;
        outcome_t                 want;
    } plan_row_t;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;

    recovery_deploy_decider_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ---------------------------------------------------------------------
    // Decision model: own copy of registers and averaging state
    // ---------------------------------------------------------------------
    logic                    safety_q, launch_q;
    logic [TILT_THR_W-1:0]   tilt_thr_q;
    logic [DROP_THR_W-1:0]   drop_thr_q;
    logic [TIME_THR_W-1:0]   time_thr_q;
    logic [WIN_W-1:0]        window_q;

    logic signed [ALT_W-1:0] alt_ring [AVG_DEPTH];
    int                      ring_ptr;
    longint                  alt_sum;
    logic signed [ALT_W-1:0] mean_alt;
    logic signed [ALT_W-1:0] peak_mean;
    logic                    decided;
    t_deploy                 decided_kind;
    logic                    servo_latched;

    outcome_t                decisions_due [$];

    int          mismatch_count = 0;
    int          results_seen   = 0;
    int          items_sent     = 0;
    int          kind_seen [8];
    int unsigned cycle_count    = 0;

    // 0: free running, 1: sender gaps, 2: receiver stalls, 3: both
    int          idle_mode      = 0;
    int          hold_token     = 0;
    int          hold_taken     = 0;
    int          hold_left      = 0;

    task automatic model_reset();
        safety_q   = 1'b1;
        launch_q   = 1'b1;
        tilt_thr_q = RST_TILT_THR;
        drop_thr_q = RST_DROP_THR;
        time_thr_q = RST_TIME_THR;
        window_q   = RST_TILT_WIN;
        foreach (alt_ring[k]) alt_ring[k] = '0;
        ring_ptr      = 0;
        alt_sum       = 0;
        mean_alt      = '0;
        peak_mean     = '0;
        decided       = 1'b0;
        decided_kind  = DEP_NONE;
        servo_latched = 1'b0;
    endtask

    // Priority chain: manual, tilt in window, apogee drop, elapsed time.
    // The ring only moves when the apogee test is reached.
    task automatic judge_sample(input sample_t s, output outcome_t r);
        int          tilt_v;
        int          thr_v;
        int unsigned ms_in_sec;
        longint      gap;
        t_deploy     kind;
        if (!safety_q && !launch_q) begin
            tilt_v    = s.tilt;
            thr_v     = tilt_thr_q;
            ms_in_sec = s.time_ms % MS_PER_SEC;
            kind      = DEP_NONE;
            if (s.manual) begin
                kind = DEP_MANUAL;
            end else if (ms_in_sec < window_q && tilt_v > thr_v) begin
                kind = DEP_TILT;
            end else begin
                alt_sum = alt_sum - alt_ring[ring_ptr] + s.alt;
                alt_ring[ring_ptr] = s.alt;
                ring_ptr = (ring_ptr + 1) % AVG_DEPTH;
                mean_alt = ALT_W'(alt_sum >>> AVG_LOG2);   // floor division
                if (mean_alt >= peak_mean) peak_mean = mean_alt;
                gap = longint'(peak_mean) - longint'(mean_alt);
                if (gap > longint'(drop_thr_q)) begin
                    kind = DEP_ALT;
                end else if (s.time_ms >= time_thr_q) begin
                    kind = DEP_TIME;
                end
            end
            decided_kind = kind;
            decided      = (kind != DEP_NONE);
            if (decided) servo_latched = 1'b1;
        end
        r.kind     = decided ? decided_kind : DEP_NONE;
        r.deployed = decided;
        r.servo    = servo_latched;
        r.avg      = mean_alt;
    endtask

    // ---------------------------------------------------------------------
    // Drivers (called at the falling edge, return at the falling edge)
    // ---------------------------------------------------------------------
    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        case (idx)
            CFG_SAFETY_PIN:     safety_q   = val[0];
            CFG_LAUNCH_PIN:     launch_q   = val[0];
            CFG_TILT_THRESHOLD: tilt_thr_q = val[TILT_THR_W-1:0];
            CFG_DROP_THRESHOLD: drop_thr_q = val[DROP_THR_W-1:0];
            CFG_TIME_THRESHOLD: time_thr_q = val[TIME_THR_W-1:0];
            CFG_TILT_WINDOW:    window_q   = val[WIN_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic send_sample(input sample_t s, input bit typed, input outcome_t want);
        outcome_t got;
        while ((idle_mode == 1 && $urandom_range(0, 99) < 64) ||
               (idle_mode == 3 && $urandom_range(0, 99) < 37)) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {s.manual, s.time_ms, s.alt, s.tilt};
        forever begin
            @(posedge i_clk);
            if (s_axis_tready) break;
        end
        judge_sample(s, got);
        decisions_due.push_back(typed ? want : got);
        items_sent++;
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    // wait until every decision is back, then let the pipe go quiet
    task automatic settle();
        s_axis_tvalid = 1'b0;
        while (decisions_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic sample_t mk_sample(int tilt, int alt, int t_ms, int man);
        sample_t s;
        s.tilt    = TILT_W'(tilt);
        s.alt     = ALT_W'(alt);
        s.time_ms = TIME_W'(t_ms);
        s.manual  = man[0];
        return s;
    endfunction

    // every field set by name, enum members included
    function automatic plan_row_t blank_row();
        plan_row_t p;
        p.is_cfg        = 1'b0;
        p.reg_id        = CFG_SAFETY_PIN;
        p.value         = '0;
        p.smp           = mk_sample(0, 0, 0, 0);
        p.typed         = 1'b0;
        p.want.kind     = DEP_NONE;
        p.want.deployed = 1'b0;
        p.want.servo    = 1'b0;
        p.want.avg      = '0;
        return p;
    endfunction

    function automatic plan_row_t cfg_row(t_cfg_reg idx, int unsigned val);
        plan_row_t p;
        p = blank_row();
        p.is_cfg = 1'b1;
        p.reg_id = idx;
        p.value  = CFG_DATA_W'(val);
        return p;
    endfunction

    function automatic plan_row_t smp_row(int tilt, int alt, int t_ms, int man);
        plan_row_t p;
        p = blank_row();
        p.smp = mk_sample(tilt, alt, t_ms, man);
        return p;
    endfunction

    function automatic plan_row_t chk_row(int tilt, int alt, int t_ms, int man,
                                          t_deploy kind, bit dep, bit servo, int avg);
        plan_row_t p;
        p = smp_row(tilt, alt, t_ms, man);
        p.typed         = 1'b1;
        p.want.kind     = kind;
        p.want.deployed = dep;
        p.want.servo    = servo;
        p.want.avg      = ALT_W'(avg);
        return p;
    endfunction

    // one of three corner values now and then, otherwise the random pick
    function automatic int unsigned pick_corner(int unsigned a, int unsigned b,
                                                int unsigned c, int unsigned rnd);
        case ($urandom_range(0, 7))
            0:       return a;
            1:       return b;
            2:       return c;
            default: return rnd;
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // Receiver: random stalls per phase, plus a long hold-off on request
    // ---------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready = 1'b0;
            hold_left--;
        end else if (hold_token != hold_taken) begin
            hold_taken    = hold_token;
            hold_left     = HOLD_CYCLES - 1;
            m_axis_tready = 1'b0;
        end else if (idle_mode == 2) begin
            m_axis_tready = ($urandom_range(0, 99) >= 64);
        end else if (idle_mode == 3) begin
            m_axis_tready = ($urandom_range(0, 99) >= 37);
        end else begin
            m_axis_tready = 1'b1;
        end
    end

    // Result checker: every transfer on m_axis against the oldest decision due
    always @(posedge i_clk) begin
        outcome_t               w;
        logic [OUT_DATA_W-1:0]  want_word;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            kind_seen[m_axis_tdata[2:0]]++;
            if (decisions_due.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result, got %h with nothing due",
                         $realtime, m_axis_tdata);
            end else begin
                w = decisions_due.pop_front();
                want_word = {3'b000, w.avg, w.servo, w.deployed, w.kind};
                if (m_axis_tdata !== want_word) begin
                    mismatch_count++;
                    $display("%0t: mismatch exp type=%0d dep=%0b servo=%0b avg=%0d pad=0",
                             $realtime, w.kind, w.deployed, w.servo, w.avg);
                    $display("%0t:          got type=%0d dep=%0b servo=%0b avg=%0d pad=%0d",
                             $realtime, m_axis_tdata[2:0], m_axis_tdata[3],
                             m_axis_tdata[4], $signed(m_axis_tdata[28:5]),
                             m_axis_tdata[31:29]);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d decisions outstanding",
                     cycle_count, decisions_due.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------
    initial begin
        plan_row_t   plan [$];
        sample_t     smp;
        outcome_t    none;
        int unsigned fl_ms;
        int          fl_alt;
        int          fl_vel;
        int unsigned time_pick;

        none = '{kind: DEP_NONE, deployed: 1'b0, servo: 1'b0, avg: '0};
        foreach (kind_seen[k]) kind_seen[k] = 0;
        model_reset();

        // Directed plan. Typed rows are readable at a glance; the rest use the model.
        // pins in after reset: even a manual order is ignored
        plan.push_back(chk_row(0, 0, 0, 1, DEP_NONE, 0, 0, 0));
        plan.push_back(cfg_row(CFG_SAFETY_PIN, 0));
        // launch pin still in
        plan.push_back(chk_row(18000, 8388607, 0, 1, DEP_NONE, 0, 0, 0));
        plan.push_back(cfg_row(CFG_LAUNCH_PIN, 0));
        // manual wins, ring untouched
        plan.push_back(chk_row(0, 8388607, 0, 1, DEP_MANUAL, 1, 1, 0));
        // tilt over limit inside window, ring untouched
        plan.push_back(chk_row(18000, -8388608, 1, 0, DEP_TILT, 1, 1, 0));
        // tilt equal to limit is not over: falls to apogee test with zero sample
        plan.push_back(chk_row(7000, 0, 199, 0, DEP_NONE, 0, 1, 0));
        // out of window, climb to extremes then fall below zero
        plan.push_back(smp_row(18000, 8388607, 200, 0));
        plan.push_back(smp_row(-18000, 8388607, 1999, 0));
        plan.push_back(smp_row(0, -8388608, 2500, 0));
        plan.push_back(smp_row(0, -8388608, 3000, 0));
        plan.push_back(cfg_row(CFG_DROP_THRESHOLD, 131071));
        plan.push_back(smp_row(0, -1, 2147483647, 0));
        plan.push_back(cfg_row(CFG_TIME_THRESHOLD, 0));
        plan.push_back(smp_row(0, 0, 0, 0));
        // window beyond a full second: every sample in window, zero threshold
        plan.push_back(cfg_row(CFG_TILT_THRESHOLD, 0));
        plan.push_back(cfg_row(CFG_TILT_WINDOW, 1023));
        plan.push_back(smp_row(1, 0, 999, 0));
        plan.push_back(smp_row(0, 0, 999, 0));
        // empty window, widest threshold
        plan.push_back(cfg_row(CFG_TILT_THRESHOLD, 32767));
        plan.push_back(cfg_row(CFG_TILT_WINDOW, 0));
        plan.push_back(smp_row(32767, 100, 0, 0));
        plan.push_back(cfg_row(CFG_DROP_THRESHOLD, 0));
        plan.push_back(cfg_row(CFG_TIME_THRESHOLD, 2147483647));
        plan.push_back(smp_row(-32768, 100, 2147483646, 0));
        plan.push_back(smp_row(0, 8388607, 5, 0));
        plan.push_back(smp_row(0, -8388608, 2147483647, 0));
        // pin back in: state held
        plan.push_back(cfg_row(CFG_SAFETY_PIN, 1));
        plan.push_back(smp_row(18000, 12345, 10, 1));

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                settle();
                write_reg(plan[i].reg_id, plan[i].value);
            end else begin
                send_sample(plan[i].smp, plan[i].typed, plan[i].want);
            end
        end

        // Random phases: mostly coherent flight profiles, some raw noise
        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            idle_mode = ph % 4;
            fl_ms  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2147480000)
                                                 : $urandom_range(0, 3000);
            fl_alt = int'($urandom_range(0, 2000)) - 1000;
            fl_vel = $urandom_range(200, 3000);
            time_pick = pick_corner(0, 2147483647, 9000,
                                    (fl_ms + $urandom_range(0, 4000)) & 32'h7FFF_FFFF);

            write_reg(CFG_SAFETY_PIN, CFG_DATA_W'($urandom_range(0, 7) == 0));
            write_reg(CFG_LAUNCH_PIN, CFG_DATA_W'($urandom_range(0, 7) == 0));
            write_reg(CFG_TILT_THRESHOLD,
                      CFG_DATA_W'(pick_corner(0, 18000, 32767,
                                              $urandom_range(1000, 9000))));
            write_reg(CFG_DROP_THRESHOLD,
                      CFG_DATA_W'(pick_corner(0, 100000, 131071,
                                              $urandom_range(50, 3000))));
            write_reg(CFG_TIME_THRESHOLD, CFG_DATA_W'(time_pick));
            write_reg(CFG_TILT_WINDOW,
                      CFG_DATA_W'(pick_corner(0, 1000, 1023, $urandom_range(0, 999))));

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // long receiver hold-off while the sender keeps offering
                if ((ph == 1 || ph == 5) && n == 30) hold_token++;
                if ($urandom_range(0, 99) < 15) begin
                    smp.tilt    = TILT_W'($urandom);
                    smp.alt     = ALT_W'($urandom);
                    smp.time_ms = TIME_W'($urandom);
                    smp.manual  = 1'($urandom);
                end else begin
                    fl_ms  = (fl_ms + $urandom_range(1, 40)) & 32'h7FFF_FFFF;
                    fl_alt = fl_alt + fl_vel;
                    fl_vel = fl_vel - int'($urandom_range(5, 40));
                    if (fl_alt > 8388000)  fl_alt = 8388000;
                    if (fl_alt < -8388000) fl_alt = -8388000;
                    smp.alt     = ALT_W'(fl_alt + int'($urandom_range(0, 200)) - 100);
                    smp.time_ms = TIME_W'(fl_ms);
                    smp.tilt    = ($urandom_range(0, 19) == 0)
                                ? TILT_W'(int'($urandom_range(0, 36000)) - 18000)
                                : TILT_W'(int'($urandom_range(0, 6000)) - 3000);
                    smp.manual  = ($urandom_range(0, 59) == 0);
                end
                send_sample(smp, 1'b0, none);
            end
        end

        settle();
        idle_mode = 0;
        $display("%0d samples, %0d decisions checked in %0d cycles over %0d phases",
                 items_sent, results_seen, cycle_count, PHASES);
        $display("deploys seen: tilt %0d, apogee %0d, time %0d, manual %0d, none %0d",
                 kind_seen[DEP_TILT], kind_seen[DEP_ALT], kind_seen[DEP_TIME],
                 kind_seen[DEP_MANUAL], kind_seen[DEP_NONE]);
        if (mismatch_count == 0 && decisions_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
src/rdd_pkg.sv
src/rdd_cell.sv
src/rdd_window.sv
src/recovery_deploy_decider_top.sv
test/recovery_deploy_decider_top_tb.sv
